// ===== sv/vtp_pkg.sv =====
// Shared types and constants for the vertex transform and projection block.
`timescale 1ns / 1ps
package vtp_pkg;

  localparam int COEF_W    = 32;
  localparam int FIELD_W   = 32;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 3;
  localparam int REG_W     = 64;
  localparam int PROD_W    = 2 * COEF_W;
  localparam int SUM_W     = PROD_W + 2;

  localparam logic [REG_W-1:0] ONE_LO = 64'd16384;
  localparam logic [REG_W-1:0] ONE_HI = 64'd16384 << 32;

  localparam logic [REG_W-1:0] REG_RESET [NUM_REGS] = '{
    ONE_LO, 64'd0, ONE_HI, 64'd0, 64'd0, ONE_LO, 64'd0, ONE_HI
  };

  typedef struct packed {
    logic                      req_type;
    logic signed [FIELD_W-1:0] in_x;
    logic signed [FIELD_W-1:0] in_y;
    logic signed [FIELD_W-1:0] in_z;
    logic signed [FIELD_W-1:0] in_w;
  } vtx_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] out_x;
    logic signed [FIELD_W-1:0] out_y;
    logic signed [FIELD_W-1:0] out_z;
    logic signed [FIELD_W-1:0] out_w;
    logic                      sum_overflow;
    logic                      zero_depth;
  } res_t;

endpackage

// ===== sv/vertex_transform_project.sv =====
// Top level: 4x4 fixed-point vertex transform with optional divide by depth.
`timescale 1ns / 1ps
// One vertex is taken per clock and one result leaves per clock. Each item
// passes a multiply stage (sixteen 32x32 products), a sum stage, a saturate
// stage, DATA_WIDTH+FRAC_BITS stages of a restoring divider (one quotient bit
// per stage, x and y side by side) and a final sign and saturate stage. The
// whole pipeline holds while a result waits with res_stall high. Matrix registers
// are written through the cfg port, always ready; write only while idle.
module vertex_transform_project
  import vtp_pkg::*;
#(
  parameter int FRAC_BITS  = 14,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vtx_valid,
  output logic                 vtx_stall,
  input  vtx_t                 vtx,
  output logic                 res_valid,
  input  logic                 res_stall,
  output res_t                 res,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data
);

  localparam int DW = DATA_WIDTH;
  localparam int NW = DATA_WIDTH + FRAC_BITS;

  localparam logic signed [SUM_W-1:0] SUM_MAX = (SUM_W'(1) <<< (DW - 1)) - SUM_W'(1);
  localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_MAX - SUM_W'(1);
  localparam logic signed [DW-1:0]    VAL_MAX = {1'b0, {(DW - 1){1'b1}}};
  localparam logic signed [DW-1:0]    VAL_MIN = {1'b1, {(DW - 1){1'b0}}};
  localparam logic [NW-1:0]           Q_MAX   = NW'(VAL_MAX);
  localparam logic [NW-1:0]           Q_NEG   = Q_MAX + NW'(1);

  typedef struct packed {
    logic                 req;
    logic                 ovf;
    logic                 zero;
    logic                 xneg;
    logic                 yneg;
    logic                 zneg;
    logic signed [DW-1:0] rx;
    logic signed [DW-1:0] ry;
    logic signed [DW-1:0] rz;
    logic signed [DW-1:0] rw;
    logic [DW-1:0]        den;
    logic [DW-1:0]        remx;
    logic [DW-1:0]        remy;
    logic [NW-1:0]        qx;
    logic [NW-1:0]        qy;
  } div_t;

  logic [REG_W-1:0] regs [NUM_REGS];

  logic adv;

  logic                      s1_valid;
  logic                      s1_req;
  logic signed [PROD_W-1:0]  prod [4][4];
  logic                      s2_valid;
  logic                      s2_req;
  logic signed [SUM_W-1:0]   sums [4];
  logic [NW:0]               dvalid;
  div_t                      dv [NW+1];
  div_t                      dv_next [NW+1];
  logic                      s_out_valid;
  res_t                      res_next;

  logic signed [FIELD_W-1:0] vin [4];
  logic signed [DW-1:0]      cl [4];
  logic                      cl_ovf;

  assign cfg_ready = 1'b1;
  assign adv       = !res_valid || !res_stall;
  assign vtx_stall = !adv;
  assign res_valid = s_out_valid;

  assign vin[0] = vtx.in_x;
  assign vin[1] = vtx.in_y;
  assign vin[2] = vtx.in_z;
  assign vin[3] = vtx.in_w;

  function automatic logic signed [COEF_W-1:0] coef_of(input logic [REG_W-1:0] r,
                                                      input int i);
    logic signed [COEF_W-1:0] c;
    c = (i % 2 == 1) ? r[REG_W-1:COEF_W] : r[COEF_W-1:0];
    return c;
  endfunction

  function automatic div_t div_step(input div_t d);
    div_t        o;
    logic [DW:0] sx;
    logic [DW:0] sy;
    logic [DW:0] dd;
    o  = d;
    dd = {1'b0, d.den};
    sx = {d.remx, d.qx[NW-1]};
    sy = {d.remy, d.qy[NW-1]};
    if (sx >= dd) begin
      o.remx = DW'(sx - dd);
      o.qx   = {d.qx[NW-2:0], 1'b1};
    end else begin
      o.remx = sx[DW-1:0];
      o.qx   = {d.qx[NW-2:0], 1'b0};
    end
    if (sy >= dd) begin
      o.remy = DW'(sy - dd);
      o.qy   = {d.qy[NW-2:0], 1'b1};
    end else begin
      o.remy = sy[DW-1:0];
      o.qy   = {d.qy[NW-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    logic [DW-1:0] m;
    m = v[DW-1] ? DW'(-v) : DW'(v);
    return m;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_REGS; k++) begin
        regs[k] <= REG_RESET[k];
      end
    end else if (cfg_valid && cfg_ready) begin
      regs[cfg_index] <= cfg_data;
    end
  end

  // saturate sums, load the divider and compute every divider step
  always_comb begin
    cl_ovf = 1'b0;
    for (int r = 0; r < 4; r++) begin
      if (sums[r] > SUM_MAX) begin
        cl[r]  = VAL_MAX;
        cl_ovf = 1'b1;
      end else if (sums[r] < SUM_MIN) begin
        cl[r]  = VAL_MIN;
        cl_ovf = 1'b1;
      end else begin
        cl[r] = DW'(sums[r]);
      end
    end
    dv_next[0].req  = s2_req;
    dv_next[0].ovf  = cl_ovf;
    dv_next[0].zero = (cl[2] == '0);
    dv_next[0].xneg = cl[0][DW-1];
    dv_next[0].yneg = cl[1][DW-1];
    dv_next[0].zneg = cl[2][DW-1];
    dv_next[0].rx   = cl[0];
    dv_next[0].ry   = cl[1];
    dv_next[0].rz   = cl[2];
    dv_next[0].rw   = cl[3];
    dv_next[0].den  = mag(cl[2]);
    dv_next[0].remx = '0;
    dv_next[0].remy = '0;
    dv_next[0].qx   = {mag(cl[0]), {FRAC_BITS{1'b0}}};
    dv_next[0].qy   = {mag(cl[1]), {FRAC_BITS{1'b0}}};
    for (int k = 0; k < NW; k++) begin
      dv_next[k+1] = div_step(dv[k]);
    end
  end

  // sign, saturate and pick the result
  always_comb begin
    logic                 ovf;
    logic signed [DW-1:0] qx;
    logic signed [DW-1:0] qy;
    logic                 nx;
    logic                 ny;
    div_t                 d;
    d   = dv[NW];
    ovf = d.ovf;
    nx  = d.xneg ^ d.zneg;
    ny  = d.yneg ^ d.zneg;
    if (nx) begin
      if (d.qx > Q_NEG) begin
        qx = VAL_MIN;
        ovf = d.req ? 1'b1 : ovf;
      end else begin
        qx = DW'(-d.qx);
      end
    end else begin
      if (d.qx > Q_MAX) begin
        qx = VAL_MAX;
        ovf = d.req ? 1'b1 : ovf;
      end else begin
        qx = DW'(d.qx);
      end
    end
    if (ny) begin
      if (d.qy > Q_NEG) begin
        qy = VAL_MIN;
        ovf = d.req ? 1'b1 : ovf;
      end else begin
        qy = DW'(-d.qy);
      end
    end else begin
      if (d.qy > Q_MAX) begin
        qy = VAL_MAX;
        ovf = d.req ? 1'b1 : ovf;
      end else begin
        qy = DW'(d.qy);
      end
    end
    if (d.req && d.zero) begin
      qx  = d.xneg ? VAL_MIN : VAL_MAX;
      qy  = d.yneg ? VAL_MIN : VAL_MAX;
      ovf = 1'b1;
    end
    if (!d.req) begin
      qx  = d.rx;
      qy  = d.ry;
      ovf = d.ovf;
    end
    res_next.out_x        = FIELD_W'(qx);
    res_next.out_y        = FIELD_W'(qy);
    res_next.out_z        = FIELD_W'(d.rz);
    res_next.out_w        = FIELD_W'(d.rw);
    res_next.sum_overflow = ovf;
    res_next.zero_depth   = d.req && d.zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid    <= 1'b0;
      s2_valid    <= 1'b0;
      dvalid      <= '0;
      s_out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid    <= vtx_valid;
      s2_valid    <= s1_valid;
      dvalid      <= {dvalid[NW-1:0], s2_valid};
      s_out_valid <= dvalid[NW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req <= vtx.req_type;
      for (int r = 0; r < 4; r++) begin
        for (int i = 0; i < 4; i++) begin
          prod[r][i] <= vin[i] * coef_of(regs[r * 2 + i / 2], i);
        end
      end
      s2_req <= s1_req;
      for (int r = 0; r < 4; r++) begin
        sums[r] <= SUM_W'(prod[r][0] >>> FRAC_BITS) + SUM_W'(prod[r][1] >>> FRAC_BITS)
                 + SUM_W'(prod[r][2] >>> FRAC_BITS) + SUM_W'(prod[r][3] >>> FRAC_BITS);
      end
      for (int k = 0; k <= NW; k++) begin
        dv[k] <= dv_next[k];
      end
      res <= res_next;
    end
  end

endmodule

// ===== dv/vertex_transform_project_tb.sv =====
// Testbench for the vertex transform block: predicts each result and compares it field by field.
`timescale 1ns / 1ps
module vertex_transform_project_tb;
  import vtp_pkg::*;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 vtx_valid = 1'b0;
  logic                 vtx_stall;
  vtx_t                 vtx = '0;
  logic                 res_valid;
  logic                 res_stall = 1'b0;
  res_t                 res;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0]     cfg_data = '0;

  localparam int FRAC = 14;
  localparam int LAT  = 50;

  logic [REG_W-1:0] matrix [NUM_REGS];
  res_t             pending_res [$];
  int               errors = 0;
  bit               calm = 1'b0;

  vertex_transform_project DUT (.*);

  always #2 clk = ~clk;

  function automatic longint floor_shift(longint p);
    return p >>> FRAC;
  endfunction

  function automatic longint sat32(longint v, ref bit ovf);
    if (v > 64'sd2147483647) begin
      ovf = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      ovf = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint coef_at(int r, int i);
    logic [REG_W-1:0] w;
    w = matrix[r * 2 + i / 2];
    return (i % 2) ? longint'($signed(w[63:32])) : longint'($signed(w[31:0]));
  endfunction

  function automatic longint depth_divide(longint num, longint den, ref bit ovf);
    if (den == 0) begin
      ovf = 1'b1;
      return (num >= 0) ? 64'sd2147483647 : -64'sd2147483648;
    end
    return sat32((num * 16384) / den, ovf);
  endfunction

  function automatic res_t transform_vertex(vtx_t v);
    longint comp [4];
    longint sums [4];
    longint acc;
    bit     ovf;
    res_t   r;
    ovf = 1'b0;
    comp[0] = longint'(v.in_x);
    comp[1] = longint'(v.in_y);
    comp[2] = longint'(v.in_z);
    comp[3] = longint'(v.in_w);
    for (int row = 0; row < 4; row++) begin
      acc = 0;
      for (int i = 0; i < 4; i++) acc += floor_shift(comp[i] * coef_at(row, i));
      sums[row] = sat32(acc, ovf);
    end
    r.zero_depth = 1'b0;
    if (v.req_type) begin
      r.zero_depth = (sums[2] == 0);
      sums[0] = depth_divide(sums[0], sums[2], ovf);
      sums[1] = depth_divide(sums[1], sums[2], ovf);
    end
    r.out_x = sums[0][31:0];
    r.out_y = sums[1][31:0];
    r.out_z = sums[2][31:0];
    r.out_w = sums[3][31:0];
    r.sum_overflow = ovf;
    return r;
  endfunction

  function automatic bit idle_now();
    return !calm && ($urandom_range(99) < 13);
  endfunction

  always @(posedge clk) begin
    if (!rst) res_stall <= idle_now();
  end

  always @(posedge clk) begin
    res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (pending_res.size() == 0) begin
        $error("result with nothing pending");
        errors++;
      end else begin
        e = pending_res.pop_front();
        if (res.out_x !== e.out_x) begin
          $error("out_x exp %0d got %0d", e.out_x, res.out_x); errors++;
        end
        if (res.out_y !== e.out_y) begin
          $error("out_y exp %0d got %0d", e.out_y, res.out_y); errors++;
        end
        if (res.out_z !== e.out_z) begin
          $error("out_z exp %0d got %0d", e.out_z, res.out_z); errors++;
        end
        if (res.out_w !== e.out_w) begin
          $error("out_w exp %0d got %0d", e.out_w, res.out_w); errors++;
        end
        if (res.sum_overflow !== e.sum_overflow) begin
          $error("sum_overflow exp %0b got %0b", e.sum_overflow, res.sum_overflow);
          errors++;
        end
        if (res.zero_depth !== e.zero_depth) begin
          $error("zero_depth exp %0b got %0b", e.zero_depth, res.zero_depth);
          errors++;
        end
      end
    end
  end

  task automatic send_vertex(vtx_t v);
    cfg_valid <= 1'b0;
    while (idle_now()) begin
      vtx_valid <= 1'b0;
      @(posedge clk);
    end
    vtx_valid <= 1'b1;
    vtx <= v;
    @(posedge clk);
    while (vtx_stall) @(posedge clk);
    pending_res.push_back(transform_vertex(v));
  endtask

  task automatic drain();
    vtx_valid <= 1'b0;
    while (pending_res.size() != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [REG_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_data <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    matrix[idx] = d;
  endtask

  function automatic logic [31:0] edgy_word();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return 32'hffffffff;
      4: return 32'd16384;
      5: return -32'sd16384;
      6: return $urandom_range(65535) - 32768;
      default: return $urandom;
    endcase
  endfunction

  function automatic vtx_t mixed_vertex();
    vtx_t v;
    v.req_type = 1'($urandom_range(1));
    v.in_x = ($urandom_range(3) == 0) ? edgy_word() : ($urandom_range(1 << 20) - (1 << 19));
    v.in_y = ($urandom_range(3) == 0) ? edgy_word() : ($urandom_range(1 << 20) - (1 << 19));
    v.in_z = ($urandom_range(3) == 0) ? edgy_word() : ($urandom_range(1 << 20) - (1 << 19));
    v.in_w = ($urandom_range(3) == 0) ? edgy_word() : ($urandom_range(1 << 20) - (1 << 19));
    return v;
  endfunction

  task automatic test_directed_identity();
    logic [31:0] ext [6];
    ext = '{32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 32'd16384, 32'h55555555};
    for (int k = 0; k < 6; k++) begin
      send_vertex('{1'b0, ext[k], ext[(k + 1) % 6], ext[(k + 2) % 6], ext[(k + 3) % 6]});
      send_vertex('{1'b1, ext[k], ext[(k + 3) % 6], ext[(k + 2) % 6], ext[(k + 1) % 6]});
    end
    // zero depth with both signs of dividend, and a quotient that saturates
    send_vertex('{1'b1, 32'd5, -32'sd5, 32'd0, 32'd1});
    send_vertex('{1'b1, 32'd0, 32'h80000000, 32'd0, 32'd0});
    send_vertex('{1'b1, 32'h7fffffff, 32'h80000000, 32'd1, 32'd0});
    send_vertex('{1'b1, 32'd40000, -32'sd40000, -32'sd3, 32'd7});
    drain();
  endtask

  task automatic test_matrix_extremes();
    for (int r = 0; r < NUM_REGS; r++) write_reg(r, 64'h7fffffff_7fffffff);
    for (int k = 0; k < 5; k++) send_vertex(mixed_vertex());
    drain();
    for (int r = 0; r < NUM_REGS; r++) write_reg(r, 64'h80000000_80000000);
    for (int k = 0; k < 5; k++) send_vertex(mixed_vertex());
    drain();
    for (int r = 0; r < NUM_REGS; r++) write_reg(r, 64'h0);
    send_vertex(mixed_vertex());
    send_vertex('{1'b1, 32'd1, 32'd1, 32'd1, 32'd1});
    drain();
  endtask

  task automatic test_random_matrices();
    for (int phase = 0; phase < 18; phase++) begin
      for (int r = 0; r < NUM_REGS; r++) begin
        if (phase % 3 == 0) write_reg(r, {edgy_word(), edgy_word()});
        else write_reg(r, {32'($urandom_range(65536) - 32768),
                           32'($urandom_range(65536) - 32768)});
      end
      calm = (phase == 9);
      for (int k = 0; k < 100; k++) send_vertex(mixed_vertex());
      calm = 1'b0;
      drain();
    end
    for (int r = 0; r < NUM_REGS; r++) write_reg(r, REG_RESET[r]);
    for (int k = 0; k < 50; k++) send_vertex(mixed_vertex());
    drain();
  endtask

  initial begin
    for (int r = 0; r < NUM_REGS; r++) matrix[r] = REG_RESET[r];
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_identity();
    test_matrix_extremes();
    test_random_matrices();
    if (errors == 0 && pending_res.size() == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #2000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
